>>> sv/dmic_pkg.sv
// Shared types and codes for the dual mask interrupt controller.
`default_nettype none

package dmic_pkg;

    // Operation codes carried in the operation field
    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_RAISE = 3'd2;
    localparam logic [2:0] OP_LOWER = 3'd3;
    localparam logic [2:0] OP_WARM  = 3'd4;

    // Register map
    localparam logic [2:0] REG_SYS_MASK    = 3'd0;
    localparam logic [2:0] REG_SYS_PENDING = 3'd1;
    localparam logic [2:0] REG_SYS_SOFT    = 3'd2;
    localparam logic [2:0] REG_VME_SOFT    = 3'd3;
    localparam logic [2:0] REG_GENERAL_ONE = 3'd4;
    localparam logic [2:0] REG_GENERAL_TWO = 3'd5;
    localparam logic [2:0] REG_VME_MASK    = 3'd6;
    localparam logic [2:0] REG_VME_PENDING = 3'd7;

    // Levels routed to the VME pending byte
    localparam logic [2:0] LEVEL_VME_LO = 3'd5;
    localparam logic [2:0] LEVEL_VME_HI = 3'd6;

    // Level masks and reset values
    localparam logic [7:0] SYS_KEEP        = 8'h9f;
    localparam logic [7:0] VME_KEEP        = 8'h60;
    localparam logic [7:0] GENERAL_ONE_RST = 8'h01;
    localparam logic [7:0] SOFT_LEVEL_BIT  = 8'h02;

    // Input word
    typedef struct packed {
        logic [2:0] operation;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [2:0] irq_level;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] pending_levels;
    } t_out_word;

endpackage

`default_nettype wire

>>> sv/dmic_regs.sv
// Register bank and interrupt routing logic of the dual mask interrupt controller.
`default_nettype none

module dmic_regs (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire dmic_pkg::t_in_word i_item,
    output dmic_pkg::t_out_word    o_result
);

    logic [7:0] r_sys_mask,    n_sys_mask;
    logic [7:0] r_sys_pending, n_sys_pending;
    logic [7:0] r_sys_soft,    n_sys_soft;
    logic [7:0] r_vme_mask,    n_vme_mask;
    logic [7:0] r_vme_pending, n_vme_pending;
    logic [7:0] r_vme_soft,    n_vme_soft;
    logic [7:0] r_general_one, n_general_one;
    logic [7:0] r_general_two, n_general_two;
    logic [7:0] rd_data;
    logic [7:0] level_bit;
    logic       level_is_vme;

    // Decode the level into a bit and pick its pending byte
    assign level_bit    = 8'h01 << i_item.irq_level;
    assign level_is_vme = (i_item.irq_level == dmic_pkg::LEVEL_VME_LO) ||
                          (i_item.irq_level == dmic_pkg::LEVEL_VME_HI);

    // Work out the next register values and the read word
    always_comb begin
        n_sys_mask    = r_sys_mask;
        n_sys_pending = r_sys_pending;
        n_sys_soft    = r_sys_soft;
        n_vme_mask    = r_vme_mask;
        n_vme_pending = r_vme_pending;
        n_vme_soft    = r_vme_soft;
        n_general_one = r_general_one;
        n_general_two = r_general_two;
        rd_data       = 8'h00;
        case (i_item.operation)
            dmic_pkg::OP_READ: begin
                case (i_item.reg_index)
                    dmic_pkg::REG_SYS_MASK: begin
                        rd_data       = r_sys_mask;
                        n_sys_pending = 8'h00;
                    end
                    dmic_pkg::REG_SYS_PENDING: rd_data = r_sys_pending;
                    dmic_pkg::REG_SYS_SOFT:    rd_data = r_sys_soft;
                    dmic_pkg::REG_VME_SOFT:    rd_data = r_vme_soft;
                    dmic_pkg::REG_GENERAL_ONE: rd_data = r_general_one;
                    dmic_pkg::REG_GENERAL_TWO: rd_data = r_general_two;
                    dmic_pkg::REG_VME_MASK: begin
                        rd_data       = r_vme_mask;
                        n_vme_pending = 8'h00;
                    end
                    default: rd_data = r_vme_pending;
                endcase
            end
            dmic_pkg::OP_WRITE: begin
                case (i_item.reg_index)
                    dmic_pkg::REG_SYS_MASK: begin
                        n_sys_mask    = i_item.write_data;
                        n_sys_pending = 8'h00;
                    end
                    dmic_pkg::REG_SYS_SOFT: begin
                        // Bit 0 of the trigger drives the soft interrupt level
                        n_sys_soft = i_item.write_data;
                        if (i_item.write_data[0]) begin
                            n_sys_pending = r_sys_pending | dmic_pkg::SOFT_LEVEL_BIT;
                        end else begin
                            n_sys_pending = r_sys_pending & ~dmic_pkg::SOFT_LEVEL_BIT;
                        end
                    end
                    dmic_pkg::REG_VME_SOFT:    n_vme_soft    = i_item.write_data;
                    dmic_pkg::REG_GENERAL_ONE: n_general_one = i_item.write_data;
                    dmic_pkg::REG_GENERAL_TWO: n_general_two = i_item.write_data;
                    dmic_pkg::REG_VME_MASK: begin
                        n_vme_mask    = i_item.write_data;
                        n_vme_pending = 8'h00;
                    end
                    default: ; // pending bytes are read-only
                endcase
            end
            dmic_pkg::OP_RAISE: begin
                if (level_is_vme) begin
                    n_vme_pending = r_vme_pending | level_bit;
                end else begin
                    n_sys_pending = r_sys_pending | level_bit;
                end
            end
            dmic_pkg::OP_LOWER: begin
                if (level_is_vme) begin
                    n_vme_pending = r_vme_pending & ~level_bit;
                end else begin
                    n_sys_pending = r_sys_pending & ~level_bit;
                end
            end
            dmic_pkg::OP_WARM: begin
                // Clear all but the general registers: the second keeps its value, the first gets its reset value
                n_sys_mask    = 8'h00;
                n_sys_pending = 8'h00;
                n_sys_soft    = 8'h00;
                n_vme_mask    = 8'h00;
                n_vme_pending = 8'h00;
                n_vme_soft    = 8'h00;
                n_general_one = dmic_pkg::GENERAL_ONE_RST;
            end
            default: ;
        endcase
    end

    // Form the result word from the updated state
    assign o_result.read_data      = rd_data;
    assign o_result.pending_levels = (n_sys_pending & n_sys_mask & dmic_pkg::SYS_KEEP) |
                                     (n_vme_pending & n_vme_mask & dmic_pkg::VME_KEEP);

    // Commit the update when a word is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sys_mask    <= 8'h00;
            r_sys_pending <= 8'h00;
            r_sys_soft    <= 8'h00;
            r_vme_mask    <= 8'h00;
            r_vme_pending <= 8'h00;
            r_vme_soft    <= 8'h00;
            r_general_one <= dmic_pkg::GENERAL_ONE_RST;
            r_general_two <= 8'h00;
        end else if (i_fire) begin
            r_sys_mask    <= n_sys_mask;
            r_sys_pending <= n_sys_pending;
            r_sys_soft    <= n_sys_soft;
            r_vme_mask    <= n_vme_mask;
            r_vme_pending <= n_vme_pending;
            r_vme_soft    <= n_vme_soft;
            r_general_one <= n_general_one;
            r_general_two <= n_general_two;
        end
    end

    // VME pending byte only ever collects levels 5 and 6
    a_vme_levels_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vme_pending & ~dmic_pkg::VME_KEEP) == 8'h00)
        else $error("VME pending byte holds a system level");

    // Writing the system mask leaves its pending byte empty
    a_sys_mask_write_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.operation == dmic_pkg::OP_WRITE &&
         i_item.reg_index == dmic_pkg::REG_SYS_MASK) |=> (r_sys_pending == 8'h00))
        else $error("system pending not cleared by mask write");

    // Warm reset restores the first general register and clears the VME mask
    a_warm_general_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.operation == dmic_pkg::OP_WARM) |=>
        (r_general_one == dmic_pkg::GENERAL_ONE_RST && r_vme_mask == 8'h00))
        else $error("warm reset did not restore registers");

    // Second general register changes only through its own write
    a_general_two_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_fire && i_item.operation == dmic_pkg::OP_WRITE &&
          i_item.reg_index == dmic_pkg::REG_GENERAL_TWO) |=> $stable(r_general_two))
        else $error("second general register changed without a write");

endmodule

`default_nettype wire

>>> sv/dual_mask_interrupt_controller_unit.sv
// Top level of the dual mask interrupt controller: input register, register bank, result register.
`default_nettype none

// Takes one word per cycle unless the output side stalls (a register read or write,
// raising or lowering an interrupt level, or a warm reset) and returns one result word
// per input word, carrying the read byte (zero unless a read) and the unmasked pending
// levels after that operation. Each word waits in the input register and moves into the
// result register once that register is free or being emptied; the only limit on the
// flow is the result register, which holds while the output side stalls. Levels 5 and 6
// are collected in the VME pending byte, all others in the system pending byte; reading
// or writing a mask register clears its pending byte.
module dual_mask_interrupt_controller_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire dmic_pkg::t_in_word i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output dmic_pkg::t_out_word     o_out_data
);

    logic                r_in_valid;
    dmic_pkg::t_in_word  r_in_word;
    logic                r_out_valid;
    dmic_pkg::t_out_word r_out_word;
    dmic_pkg::t_out_word result;
    logic                advance;

    // Move a word on when the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_data;
        end
    end

    dmic_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_word),
        .o_result (result)
    );

    // Result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

endmodule

`default_nettype wire

>>> bench/tb_dual_mask_interrupt_controller_unit.sv
// Self-checking testbench for the dual mask interrupt controller unit.
module tb_dual_mask_interrupt_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes the block does not decode
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS  = 1900;
    localparam int DIRECTED_ROWS = 26;

    typedef struct packed {
        dmic_pkg::t_in_word  word;
        logic                typed_in;
        dmic_pkg::t_out_word want;
    } t_plan_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    dmic_pkg::t_in_word  i_in_data   = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    dmic_pkg::t_out_word o_out_data;

    // Mirror of the register bank
    logic [7:0] m_sys_mask;
    logic [7:0] m_sys_pend;
    logic [7:0] m_sys_soft;
    logic [7:0] m_vme_mask;
    logic [7:0] m_vme_pend;
    logic [7:0] m_vme_soft;
    logic [7:0] m_gen_one;
    logic [7:0] m_gen_two;

    dmic_pkg::t_out_word owed_words[$];
    int                  error_count = 0;

    // Directed words: fixed results only where they follow straight from a reset or a warm reset
    t_plan_row plan [DIRECTED_ROWS] = '{
        '{'{dmic_pkg::OP_READ, dmic_pkg::REG_GENERAL_ONE, 8'h00, 3'd0}, 1'b1, '{8'h01, 8'h00}},
        '{'{dmic_pkg::OP_READ, dmic_pkg::REG_SYS_MASK, 8'h00, 3'd0}, 1'b1, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_READ, dmic_pkg::REG_GENERAL_TWO, 8'h00, 3'd0}, 1'b1, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_WRITE, dmic_pkg::REG_SYS_MASK, 8'hff, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_WRITE, dmic_pkg::REG_VME_MASK, 8'hff, 3'd7}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_RAISE, dmic_pkg::REG_SYS_MASK, 8'h00, 3'd7}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_RAISE, dmic_pkg::REG_SYS_MASK, 8'h00, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_RAISE, dmic_pkg::REG_VME_PENDING, 8'hff, 3'd5}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_RAISE, dmic_pkg::REG_VME_PENDING, 8'hff, 3'd6}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_RAISE, dmic_pkg::REG_VME_PENDING, 8'hff, 3'd2}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_WRITE, dmic_pkg::REG_SYS_PENDING, 8'h00, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_WRITE, dmic_pkg::REG_VME_PENDING, 8'hff, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_READ, dmic_pkg::REG_SYS_PENDING, 8'h00, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_READ, dmic_pkg::REG_VME_PENDING, 8'h00, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_LOWER, dmic_pkg::REG_SYS_MASK, 8'h00, 3'd7}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_LOWER, dmic_pkg::REG_SYS_MASK, 8'h00, 3'd5}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_WRITE, dmic_pkg::REG_SYS_SOFT, 8'hff, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_WRITE, dmic_pkg::REG_SYS_SOFT, 8'hfe, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_WRITE, dmic_pkg::REG_VME_SOFT, 8'ha5, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_READ, dmic_pkg::REG_VME_SOFT, 8'h00, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_WRITE, dmic_pkg::REG_GENERAL_TWO, 8'h5a, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_READ, dmic_pkg::REG_SYS_MASK, 8'h00, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{OP_SPARE_HI, dmic_pkg::REG_VME_PENDING, 8'hff, 3'd7}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_WARM, dmic_pkg::REG_SYS_MASK, 8'h00, 3'd0}, 1'b0, '{8'h00, 8'h00}},
        '{'{dmic_pkg::OP_READ, dmic_pkg::REG_GENERAL_ONE, 8'h00, 3'd0}, 1'b1, '{8'h01, 8'h00}},
        '{'{dmic_pkg::OP_READ, dmic_pkg::REG_VME_MASK, 8'h00, 3'd0}, 1'b1, '{8'h00, 8'h00}}
    };

    dual_mask_interrupt_controller_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Free-running clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Restore reset values; a warm reset keeps the second general register
    function automatic void clear_state(bit cold);
        m_sys_mask = '0;
        m_sys_pend = '0;
        m_sys_soft = '0;
        m_vme_mask = '0;
        m_vme_pend = '0;
        m_vme_soft = '0;
        m_gen_one  = dmic_pkg::GENERAL_ONE_RST;
        if (cold) begin
            m_gen_two = '0;
        end
    endfunction

    // Apply one word to the mirror and return the result word it produces
    function automatic dmic_pkg::t_out_word route_levels(dmic_pkg::t_in_word w);
        dmic_pkg::t_out_word r;
        logic [7:0]          lvl_bit;
        logic                to_vme;
        r.read_data = '0;
        lvl_bit     = 8'h01 << w.irq_level;
        to_vme      = (w.irq_level == dmic_pkg::LEVEL_VME_LO) ||
                      (w.irq_level == dmic_pkg::LEVEL_VME_HI);
        case (w.operation)
            dmic_pkg::OP_READ: begin
                case (w.reg_index)
                    dmic_pkg::REG_SYS_MASK: begin
                        r.read_data = m_sys_mask;
                        m_sys_pend  = '0;
                    end
                    dmic_pkg::REG_SYS_PENDING: r.read_data = m_sys_pend;
                    dmic_pkg::REG_SYS_SOFT:    r.read_data = m_sys_soft;
                    dmic_pkg::REG_VME_SOFT:    r.read_data = m_vme_soft;
                    dmic_pkg::REG_GENERAL_ONE: r.read_data = m_gen_one;
                    dmic_pkg::REG_GENERAL_TWO: r.read_data = m_gen_two;
                    dmic_pkg::REG_VME_MASK: begin
                        r.read_data = m_vme_mask;
                        m_vme_pend  = '0;
                    end
                    default:                   r.read_data = m_vme_pend;
                endcase
            end
            dmic_pkg::OP_WRITE: begin
                case (w.reg_index)
                    dmic_pkg::REG_SYS_MASK: begin
                        m_sys_mask = w.write_data;
                        m_sys_pend = '0;
                    end
                    // Soft interrupt follows bit 0 of the written byte onto level 1
                    dmic_pkg::REG_SYS_SOFT: begin
                        m_sys_soft = w.write_data;
                        if (w.write_data[0]) begin
                            m_sys_pend = m_sys_pend | dmic_pkg::SOFT_LEVEL_BIT;
                        end else begin
                            m_sys_pend = m_sys_pend & ~dmic_pkg::SOFT_LEVEL_BIT;
                        end
                    end
                    dmic_pkg::REG_VME_SOFT:    m_vme_soft = w.write_data;
                    dmic_pkg::REG_GENERAL_ONE: m_gen_one  = w.write_data;
                    dmic_pkg::REG_GENERAL_TWO: m_gen_two  = w.write_data;
                    dmic_pkg::REG_VME_MASK: begin
                        m_vme_mask = w.write_data;
                        m_vme_pend = '0;
                    end
                    default: ;
                endcase
            end
            dmic_pkg::OP_RAISE, dmic_pkg::OP_LOWER: begin
                if (to_vme) begin
                    m_vme_pend = (w.operation == dmic_pkg::OP_RAISE) ? (m_vme_pend | lvl_bit)
                                                                     : (m_vme_pend & ~lvl_bit);
                end else begin
                    m_sys_pend = (w.operation == dmic_pkg::OP_RAISE) ? (m_sys_pend | lvl_bit)
                                                                     : (m_sys_pend & ~lvl_bit);
                end
            end
            dmic_pkg::OP_WARM: clear_state(1'b0);
            default: ;
        endcase
        r.pending_levels = (m_sys_pend & m_sys_mask & dmic_pkg::SYS_KEEP) |
                           (m_vme_pend & m_vme_mask & dmic_pkg::VME_KEEP);
        return r;
    endfunction

    // Idle length: none when calm, else mostly none or short, now and then long
    function automatic int unsigned idle_span(bit calm);
        int unsigned r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Random word, weighted towards level traffic and register writes
    function automatic dmic_pkg::t_in_word random_word();
        dmic_pkg::t_in_word w;
        int unsigned        r;
        r = $urandom_range(0, 99);
        if (r < 22) begin
            w.operation = dmic_pkg::OP_READ;
        end else if (r < 46) begin
            w.operation = dmic_pkg::OP_WRITE;
        end else if (r < 72) begin
            w.operation = dmic_pkg::OP_RAISE;
        end else if (r < 91) begin
            w.operation = dmic_pkg::OP_LOWER;
        end else if (r < 94) begin
            w.operation = dmic_pkg::OP_WARM;
        end else begin
            w.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end
        w.reg_index  = 3'($urandom_range(0, 7));
        w.write_data = 8'($urandom_range(0, 255));
        w.irq_level  = 3'($urandom_range(0, 7));
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("%0t: %s mismatch: got %02h, expected %02h", $time, what, got, want);
        error_count++;
    endtask

    // Offer one word, hold it until taken, then record what it should produce
    task automatic send_word(dmic_pkg::t_in_word w, logic typed_in,
                             dmic_pkg::t_out_word want, int serial);
        int unsigned         gap;
        dmic_pkg::t_out_word predicted;
        gap = idle_span((serial / 128) % 4 == 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_data  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = route_levels(w);
        owed_words.push_back(typed_in ? want : predicted);
    endtask

    // Stimulus and end of run
    initial begin
        dmic_pkg::t_in_word w;
        int                 serial;
        clear_state(1'b1);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            send_word(plan[k].word, plan[k].typed_in, plan[k].want, k);
        end
        serial = 0;
        while (serial < RANDOM_WORDS) begin
            w = random_word();
            send_word(w, 1'b0, '0, serial);
            serial++;
        end
        i_in_valid <= 1'b0;
        while (owed_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Result side: check each taken word, stall at random
    initial begin
        int unsigned         stall_left;
        int unsigned         cycle_no;
        dmic_pkg::t_out_word want;
        stall_left = 0;
        cycle_no   = 0;
        forever begin
            @(posedge i_clk);
            cycle_no++;
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (owed_words.size() == 0) begin
                    report_mismatch("unrequested word", o_out_data.read_data, 8'h00);
                end else begin
                    want = owed_words.pop_front();
                    if (o_out_data.read_data !== want.read_data) begin
                        report_mismatch("read_data", o_out_data.read_data, want.read_data);
                    end
                    if (o_out_data.pending_levels !== want.pending_levels) begin
                        report_mismatch("pending_levels", o_out_data.pending_levels,
                                        want.pending_levels);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = idle_span((cycle_no / 700) % 4 == 1);
                end
            end
        end
    end

    // Watchdog
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
